// File: rtl/core/spq_pkg.sv
// Package of the sorted priority queue: capacity, field widths, operation and
// status codes, and the structs that pass between the queue cells.
// No dependencies.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
        logic signed [DATA_W-1:0] prio;
    } cell_state_t;

    typedef struct packed {
        logic                     ins;
        logic                     pop;
        logic signed [DATA_W-1:0] data;
        logic signed [DATA_W-1:0] prio;
    } cell_cmd_t;

endpackage

// File: rtl/core/spq_if.sv
// Channel interfaces of the sorted priority queue: request and response.
// Depends on spq_pkg.
interface spq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [spq_pkg::DATA_W-1:0] item_data;
    logic signed [spq_pkg::DATA_W-1:0] item_priority;

    modport source (output valid, op, item_data, item_priority, input ready);
    modport sink (input valid, op, item_data, item_priority, output ready);
endinterface

interface spq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [spq_pkg::DATA_W-1:0]  popped_data;
    logic [1:0]                         status;
    logic signed [spq_pkg::DATA_W-1:0]  head_data;
    logic                               is_empty;
    logic [spq_pkg::COUNT_W-1:0]        entry_count;

    modport source (output valid, popped_data, status, head_data, is_empty, entry_count,
                    input ready);
    modport sink (input valid, popped_data, status, head_data, is_empty, entry_count,
                  output ready);
endinterface

// File: rtl/core/spq_cell.sv
// One slot of the sorted queue. It keeps its entry, takes the new entry or
// its left neighbor's entry on an insert, and takes its right neighbor's on a pop.
// Depends on spq_pkg.
module spq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spq_pkg::cell_cmd_t   cmd,
    input  spq_pkg::cell_state_t left,
    input  logic                 left_ge,
    input  spq_pkg::cell_state_t right,
    output spq_pkg::cell_state_t cur,
    output spq_pkg::cell_state_t nxt,
    output logic                 ge
);
    import spq_pkg::*;

    cell_state_t state_reg;
    cell_state_t state_next;

    assign ge = state_reg.valid && (state_reg.prio >= cmd.prio);

    always_comb
    begin
        state_next = state_reg;
        if (cmd.ins)
        begin
            state_next.valid = state_reg.valid || left.valid;
            if (!ge)
            begin
                if (left_ge)
                begin
                    state_next.data = cmd.data;
                    state_next.prio = cmd.prio;
                end
                else
                begin
                    state_next.data = left.data;
                    state_next.prio = left.prio;
                end
            end
        end
        else if (cmd.pop)
        begin
            state_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cur = state_reg;
    assign nxt = state_next;

endmodule

// File: rtl/core/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: a row of CAPACITY cells kept sorted,
// highest priority in cell 0, and a registered response stage.
// Depends on spq_pkg, spq_if and spq_cell.
//
//  Channel | Modport | Transaction carries
//  --------+---------+--------------------------------------------------------
//  req     | sink    | op, item_data, item_priority
//  rsp     | source  | popped_data, status, head_data, is_empty, entry_count
//
// All cells compare against the new priority of a request in parallel and shift
// by one slot in the same cycle, and the response is registered, so one transaction
// is accepted per cycle while the response is not stalled, and answered on the next.
// A request is accepted while the response register is empty or being drained.
// Reset empties the queue at once; no clearing pass is needed.
module sorted_priority_queue_unit (
    input  logic         clk,
    input  logic         rst_n,
    spq_req_if.sink      req,
    spq_rsp_if.source    rsp
);
    import spq_pkg::*;

    cell_state_t cur [CAPACITY];
    cell_state_t nxt [CAPACITY];
    logic        ge  [CAPACITY];
    cell_cmd_t   cmd;

    logic        fire;
    logic        is_pop;
    logic        full;
    logic        empty;
    status_t     status;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] popped_next;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] head_reg;
    logic signed [DATA_W-1:0] head_next;
    logic                     empty_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign is_pop    = (req.op == OP_POP);
    assign full      = cur[CAPACITY-1].valid;
    assign empty     = !cur[0].valid;

    always_comb
    begin
        cmd.ins  = fire && !is_pop && !full;
        cmd.pop  = fire && is_pop && !empty;
        cmd.data = req.item_data;
        cmd.prio = req.item_priority;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_state_t left_s;
            cell_state_t right_s;
            logic        left_ge_s;

            if (i == 0)
            begin : g_first
                assign left_s    = '{valid: 1'b1, data: '0, prio: '0};
                assign left_ge_s = 1'b1;
            end
            else
            begin : g_mid
                assign left_s    = cur[i-1];
                assign left_ge_s = ge[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_s = '{valid: 1'b0, data: '0, prio: '0};
            end
            else
            begin : g_inner
                assign right_s = cur[i+1];
            end

            spq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .left    (left_s),
                .left_ge (left_ge_s),
                .right   (right_s),
                .cur     (cur[i]),
                .nxt     (nxt[i]),
                .ge      (ge[i])
            );
        end
    endgenerate

    always_comb
    begin
        status      = ST_OK;
        popped_next = '0;
        count_next  = count_reg;
        if (fire)
        begin
            if (is_pop)
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    popped_next = cur[0].data;
                    count_next  = count_reg - COUNT_W'(1);
                end
            end
            else
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
        end
        head_next      = nxt[0].valid ? nxt[0].data : '0;
        out_valid_next = fire || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            popped_reg <= popped_next;
            status_reg <= status;
            head_reg   <= head_next;
            empty_reg  <= !nxt[0].valid;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.popped_data = popped_reg;
    assign rsp.status      = status_reg;
    assign rsp.head_data   = head_reg;
    assign rsp.is_empty    = empty_reg;
    assign rsp.entry_count = count_reg;

endmodule

// File: rtl/core/spq_checker.sv
// Port-level checks of the sorted priority queue response channel, and the
// bind that attaches them to the top level. Depends on spq_pkg.
module spq_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic signed [spq_pkg::DATA_W-1:0] popped_data,
    input  logic [1:0]                        status,
    input  logic signed [spq_pkg::DATA_W-1:0] head_data,
    input  logic                              is_empty
);
    import spq_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(head_data) && $stable(status))
        else $error("Stalled response transaction changed.");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> head_data == '0)
        else $error("Empty queue reports nonzero head data.");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> is_empty && popped_data == '0)
        else $error("Pop on empty queue reported data or a nonempty queue.");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> !is_empty && popped_data == '0)
        else $error("Dropped insert reported an empty queue or popped data.");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .popped_data (rsp.popped_data),
    .status      (rsp.status),
    .head_data   (rsp.head_data),
    .is_empty    (rsp.is_empty)
);

// File: dv/spq_order_checker.sv
// Order checker of the sorted priority queue: watches both channels, predicts each
// response from its own sorted copy of the queue and compares it field by field.
// Depends on spq_pkg and spq_if.
`timescale 1ns / 100ps

module spq_order_checker (
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if          req,
    spq_rsp_if          rsp,
    output int unsigned mismatch_count,
    output int unsigned outstanding_results
);
    import spq_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_data;
        status_t                  status;
        logic signed [DATA_W-1:0] head_data;
        logic                     is_empty;
        logic [COUNT_W-1:0]       entry_count;
    } queue_result_t;

    logic signed [DATA_W-1:0] slot_data [CAPACITY];
    logic signed [DATA_W-1:0] slot_prio [CAPACITY];
    int unsigned              fill;
    queue_result_t            expected_results [$];

    task automatic apply_request(input op_t op, input logic signed [DATA_W-1:0] data,
                                 input logic signed [DATA_W-1:0] prio,
                                 output queue_result_t res);
        int unsigned pos;
        res.popped_data = '0;
        res.status      = ST_OK;
        if (op == OP_INSERT)
        begin
            if (fill >= CAPACITY)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < fill && slot_prio[pos] >= prio)
                begin
                    pos++;
                end
                for (int i = fill; i > pos; i--)
                begin
                    slot_data[i] = slot_data[i-1];
                    slot_prio[i] = slot_prio[i-1];
                end
                slot_data[pos] = data;
                slot_prio[pos] = prio;
                fill++;
            end
        end
        else
        begin
            if (fill == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.popped_data = slot_data[0];
                for (int i = 1; i < fill; i++)
                begin
                    slot_data[i-1] = slot_data[i];
                    slot_prio[i-1] = slot_prio[i];
                end
                fill--;
            end
        end
        res.head_data   = (fill > 0) ? slot_data[0] : '0;
        res.is_empty    = (fill == 0);
        res.entry_count = fill[COUNT_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t predicted;
        queue_result_t oldest;
        if (!rst_n)
        begin
            fill = 0;
            expected_results.delete();
            mismatch_count      = 0;
            outstanding_results = 0;
        end
        else
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
            begin
                apply_request(op_t'(req.op), req.item_data, req.item_priority, predicted);
                expected_results.push_back(predicted);
            end
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Response transaction arrived with no request waiting.");
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (rsp.popped_data !== oldest.popped_data)
                    begin
                        $error("popped_data: expected %0d, actual %0d",
                               oldest.popped_data, rsp.popped_data);
                        mismatch_count++;
                    end
                    if (rsp.status !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.head_data !== oldest.head_data)
                    begin
                        $error("head_data: expected %0d, actual %0d",
                               oldest.head_data, rsp.head_data);
                        mismatch_count++;
                    end
                    if (rsp.is_empty !== oldest.is_empty)
                    begin
                        $error("is_empty: expected %0d, actual %0d",
                               oldest.is_empty, rsp.is_empty);
                        mismatch_count++;
                    end
                    if (rsp.entry_count !== oldest.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               oldest.entry_count, rsp.entry_count);
                        mismatch_count++;
                    end
                end
            end
            outstanding_results = expected_results.size();
        end
    end

endmodule

// File: dv/tb_top.sv
// Top of the sorted priority queue testbench: clock, reset, request stimulus with
// random gaps, response back-pressure and the verdict.
// Depends on spq_pkg, spq_if, sorted_priority_queue_unit and spq_order_checker.
`timescale 1ns / 100ps

module tb_top;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int LONG_HOLD    = 80;

    logic        clk;
    logic        rst_n;
    logic        no_idle;
    logic        hold_pending;
    int unsigned mismatch_count;
    int unsigned outstanding_results;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    spq_order_checker i_order_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req                 (req_ch),
        .rsp                 (rsp_ch),
        .mismatch_count      (mismatch_count),
        .outstanding_results (outstanding_results)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned gap_length();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [DATA_W-1:0] random_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 7);
            5, 6, 7:       return $urandom;
            8:             return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default:       return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        endcase
    endfunction

    task automatic send_request(input op_t op, input logic signed [DATA_W-1:0] data,
                                input logic signed [DATA_W-1:0] prio);
        req_ch.valid         <= 1'b1;
        req_ch.op            <= op;
        req_ch.item_data     <= data;
        req_ch.item_priority <= prio;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
    endtask

    initial
    begin
        int unsigned hold_cycles;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending <= 1'b0;
                rsp_ch.ready <= 1'b0;
                hold_cycles = LONG_HOLD;
            end
            else if (no_idle || $urandom_range(0, 3) != 0)
            begin
                rsp_ch.ready <= 1'b1;
                hold_cycles = 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles = gap_length();
            end
            repeat (hold_cycles) @(posedge clk);
        end
    end

    initial
    begin
        int unsigned insert_weight;
        rst_n                <= 1'b0;
        no_idle              <= 1'b0;
        hold_pending         <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.op            <= OP_INSERT;
        req_ch.item_data     <= '0;
        req_ch.item_priority <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pop on an empty queue, fill past capacity with extreme and tied priorities, then pop three.
        send_request(OP_POP, 32'sh7fffffff, 32'sh80000000);
        send_request(OP_INSERT, 32'sh7fffffff, 32'sh80000000);
        send_request(OP_INSERT, 32'sh80000000, 32'sh7fffffff);
        send_request(OP_INSERT, 32'sd0, 32'sd0);
        send_request(OP_INSERT, 32'sd1, 32'sd0);
        send_request(OP_INSERT, -32'sd1, -32'sd1);
        send_request(OP_INSERT, 32'sd2, 32'sd0);
        send_request(OP_INSERT, 32'sd3, 32'sh7fffffff);
        send_request(OP_INSERT, 32'sd4, 32'sh80000000);
        send_request(OP_INSERT, 32'sd5, 32'sd1);
        send_request(OP_INSERT, 32'sd6, -32'sd1);
        send_request(OP_INSERT, 32'sh55555555, 32'sh55555555);
        send_request(OP_INSERT, 32'shaaaaaaaa, 32'shaaaaaaaa);
        send_request(OP_INSERT, 32'sd7, 32'sd0);
        send_request(OP_INSERT, 32'sd8, 32'sd1);
        send_request(OP_INSERT, 32'sd9, 32'sh7ffffffe);
        send_request(OP_INSERT, 32'sd10, 32'sh80000001);
        send_request(OP_INSERT, 32'sd11, 32'sh7fffffff);
        send_request(OP_POP, 32'sd0, 32'sd0);
        send_request(OP_POP, 32'shffffffff, 32'shffffffff);
        send_request(OP_POP, 32'sd0, 32'sd0);

        insert_weight = 5;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       insert_weight = 8;
                    1:       insert_weight = 2;
                    default: insert_weight = 5;
                endcase
                no_idle <= ($urandom_range(0, 3) == 0);
            end
            if (n == 200)
            begin
                hold_pending <= 1'b1;
            end
            if ($urandom_range(0, 9) < insert_weight)
            begin
                send_request(OP_INSERT, $urandom, random_priority());
            end
            else
            begin
                send_request(OP_POP, $urandom, $urandom);
            end
        end
        req_ch.valid <= 1'b0;

        do
        begin
            @(posedge clk);
        end
        while (outstanding_results != 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
